### rtl/mpnh_pkg.sv
// ----------------------------------------------------------------------------
// mpnh_pkg
// shared types and constants of the multiprecision number hash
// ----------------------------------------------------------------------------
package mpnh_pkg;

  localparam int LIMB_BITS  = 64;
  localparam int HASH_W     = 64;
  localparam int MAX_LIMBS  = 65536;
  localparam int CNT_W      = $clog2(MAX_LIMBS + 1);
  localparam int LIMB_SHIFT = $clog2(LIMB_BITS);
  localparam int RAT_ROT    = (HASH_W / 5) + 2;
  localparam int EXP_W      = 64;
  localparam int DIFF_W     = 66;
  localparam int DIGIT_W    = 6;
  localparam int DIGITS     = DIFF_W / DIGIT_W;
  localparam int DIGITS_LO  = 6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_RAT   = 2'd1;
  localparam logic [1:0] KIND_FLOAT = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] CLS_FINITE = 2'd0;
  localparam logic [1:0] CLS_ZERO   = 2'd1;
  localparam logic [1:0] CLS_INF    = 2'd2;
  localparam logic [1:0] CLS_NAN    = 2'd3;

  localparam logic [HASH_W-1:0] INF_HASH = HASH_W'(314159);

  typedef struct packed {
    logic [1:0] kind;
    logic       den;
    logic       inl;
    logic       last;
    logic       neg;
    logic [1:0] fclass;
  } tag_t;

  typedef struct packed {
    tag_t                  tag;
    logic [LIMB_BITS-1:0]  value;
    logic [EXP_W-1:0]      exponent;
    logic [CNT_W-1:0]      count;
  } job_t;

endpackage

### rtl/multiprecision_number_hash.sv
// ----------------------------------------------------------------------------
// multiprecision_number_hash
// hashes integers, rationals and binary floats streamed as 64-bit limbs
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata: limb, exponent; tuser: req_type, part, inline_value,
//          |     |   negative, float_class, last_of_part; tlast: last
//  out_    | out | tdata: hash_value
//
//  one limb per cycle while the queue is not full; the sum is one end-around add
//  a result passes the queue, back stages a, b and c and the output register
//  part ends go through a four-entry queue and a three-stage back pipeline
//  out_tready low stalls the back; in_tready drops only when the queue is full
//  reset clears the sums, counts, queue and numerator hash at once
// ----------------------------------------------------------------------------
module multiprecision_number_hash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // limb, exponent
  input  logic [7:0]   in_tuser,   // req_type, part, inline_value, negative,
                                   // float_class, last_of_part
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // hash_value
);

  logic           q_full;
  logic           push;
  mpnh_pkg::job_t entry;
  logic           pop;
  logic           head_valid;
  mpnh_pkg::job_t head;

  mpnh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  mpnh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mpnh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/mpnh_front.sv
// ----------------------------------------------------------------------------
// mpnh_front
// accepts limbs, folds them into the running end-around sum, queues part ends
// ----------------------------------------------------------------------------
module mpnh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [127:0]        in_tdata,  // limb, exponent
  input  logic [7:0]          in_tuser,  // req_type, part, inline_value, negative,
                                         // float_class, last_of_part
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                push,
  output mpnh_pkg::job_t      entry
);

  logic [mpnh_pkg::LIMB_BITS-1:0] sum_r, sum_nxt;
  logic [mpnh_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [1:0]                     kind;
  logic                           inl;
  logic                           end_part;
  logic                           accept;
  logic [mpnh_pkg::LIMB_BITS:0]   raw;
  logic [mpnh_pkg::LIMB_BITS-1:0] folded;
  logic [mpnh_pkg::LIMB_BITS-1:0] limb;

  assign limb      = in_tdata[63:0];
  assign kind      = (in_tuser[1:0] == mpnh_pkg::KIND_SPARE) ? mpnh_pkg::KIND_INT
                                                             : in_tuser[1:0];
  assign inl       = in_tuser[3] && (kind != mpnh_pkg::KIND_FLOAT);
  assign end_part  = in_tuser[7] || in_tlast || inl;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && end_part;

  always_comb begin
    raw    = {1'b0, sum_r} + {1'b0, limb};
    folded = raw[mpnh_pkg::LIMB_BITS-1:0] + {{(mpnh_pkg::LIMB_BITS-1){1'b0}},
                                            raw[mpnh_pkg::LIMB_BITS]};
    if (inl) begin
      sum_nxt   = sum_r;
      count_nxt = count_r;
    end else begin
      sum_nxt   = folded;
      count_nxt = (count_r < mpnh_pkg::CNT_W'(mpnh_pkg::MAX_LIMBS)) ?
                  count_r + mpnh_pkg::CNT_W'(1) : count_r;
    end
  end

  always_comb begin
    entry.tag.kind   = kind;
    entry.tag.den    = in_tuser[2];
    entry.tag.inl    = inl;
    entry.tag.last   = in_tlast;
    entry.tag.neg    = in_tuser[4];
    entry.tag.fclass = in_tuser[6:5];
    entry.value      = inl ? limb : folded;
    entry.exponent   = in_tdata[127:64];
    entry.count      = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (accept) begin
      if (end_part) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_part_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (sum_r == '0) && (count_r == '0))
    else $error("accumulator not cleared after part end");
`endif

endmodule

### rtl/mpnh_queue.sv
// ----------------------------------------------------------------------------
// mpnh_queue
// short queue of part-end jobs between the front and the back
// ----------------------------------------------------------------------------
module mpnh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mpnh_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mpnh_pkg::job_t head
);

  mpnh_pkg::job_t                 store_r [mpnh_pkg::QDEPTH];
  logic [mpnh_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [mpnh_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full       = (count_r == mpnh_pkg::QCNT_W'(mpnh_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = store_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + mpnh_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - mpnh_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mpnh_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mpnh_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");
`endif

endmodule

### rtl/mpnh_back.sv
// ----------------------------------------------------------------------------
// mpnh_back
// pipeline forming part hashes, float rotation and the rational combine
// ----------------------------------------------------------------------------
module mpnh_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  mpnh_pkg::job_t               head,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mpnh_pkg::HASH_W-1:0]  out_tdata  // hash_value
);

  localparam int HB = mpnh_pkg::HASH_W;
  localparam logic [HB-1:0] ALL_ONES = '1;

  function automatic logic [HB-1:0] rotl(input logic [HB-1:0] x, input logic [5:0] r);
    logic [2*HB-1:0] w;
    w = {x, x} << r;
    return w[2*HB-1:HB];
  endfunction

  logic                         en;

  logic                         a_valid_r;
  mpnh_pkg::tag_t               a_tag_r;
  logic [HB-1:0]                a_val_r;
  logic [mpnh_pkg::DIFF_W-1:0]  a_diff_r, a_diff_nxt;

  logic                         b_valid_r;
  mpnh_pkg::tag_t               b_tag_r;
  logic [HB-1:0]                b_val_r;
  logic                         b_neg_r;
  logic [8:0]                   b_lo_r, b_lo_nxt;
  logic [8:0]                   b_hi_r, b_hi_nxt;

  logic                         c_valid_r;
  mpnh_pkg::tag_t               c_tag_r;
  logic [HB-1:0]                c_hv_r, c_hv_nxt;

  logic [9:0]                   dsum;
  logic [6:0]                   dfold;
  logic [6:0]                   dmod;
  logic [5:0]                   amt;

  logic [HB-1:0]                fin_neg, fin, h, num_sel, res;
  logic [HB-1:0]                num_r;
  logic                         out_valid_r;
  logic [HB-1:0]                out_data_r;

  assign en         = !out_valid_r || out_tready;
  assign pop        = head_valid && en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // exponent minus the scaled limb count, kept wide enough to stay exact
  assign a_diff_nxt = {{(mpnh_pkg::DIFF_W-mpnh_pkg::EXP_W){head.exponent[mpnh_pkg::EXP_W-1]}},
                       head.exponent}
                    - {{(mpnh_pkg::DIFF_W-mpnh_pkg::CNT_W-mpnh_pkg::LIMB_SHIFT){1'b0}},
                       head.count, {mpnh_pkg::LIMB_SHIFT{1'b0}}};

  // six-bit digit sums, since 64 is one modulo 63
  always_comb begin
    b_lo_nxt = '0;
    b_hi_nxt = '0;
    for (int i = 0; i < mpnh_pkg::DIGITS_LO; i++) begin
      b_lo_nxt = b_lo_nxt + 9'(a_diff_r[i*mpnh_pkg::DIGIT_W +: mpnh_pkg::DIGIT_W]);
    end
    for (int i = mpnh_pkg::DIGITS_LO; i < mpnh_pkg::DIGITS; i++) begin
      b_hi_nxt = b_hi_nxt + 9'(a_diff_r[i*mpnh_pkg::DIGIT_W +: mpnh_pkg::DIGIT_W]);
    end
  end

  always_comb begin
    dsum  = 10'(b_lo_r) + 10'(b_hi_r);
    dfold = 7'(dsum[5:0]) + 7'(dsum[9:6]);
    dmod  = (dfold >= 7'd63) ? dfold - 7'd63 : dfold;
    // negative distance wraps by one step through the two's complement weight
    amt   = (b_neg_r && (dmod == 7'd0)) ? 6'd63 : dmod[5:0];
    c_hv_nxt = (b_tag_r.kind == mpnh_pkg::KIND_FLOAT) ? rotl(b_val_r, amt) : b_val_r;
  end

  always_comb begin
    fin_neg = c_tag_r.neg ? HB'(0) - c_hv_r : c_hv_r;
    fin     = (fin_neg == ALL_ONES) ? ALL_ONES - HB'(1) : fin_neg;
    case (c_tag_r.kind)
      mpnh_pkg::KIND_FLOAT: begin
        case (c_tag_r.fclass)
          mpnh_pkg::CLS_FINITE: h = fin;
          mpnh_pkg::CLS_INF:    h = c_tag_r.neg ? HB'(0) - mpnh_pkg::INF_HASH
                                                : mpnh_pkg::INF_HASH;
          mpnh_pkg::CLS_ZERO,
          mpnh_pkg::CLS_NAN:    h = '0;
          default:              h = '0;
        endcase
      end
      default: begin
        h = c_tag_r.inl ? c_hv_r : fin;
      end
    endcase
    num_sel = c_tag_r.den ? num_r : h;
    res     = (c_tag_r.kind == mpnh_pkg::KIND_RAT) ?
              num_sel ^ rotl(c_tag_r.den ? h : HB'(0), 6'(mpnh_pkg::RAT_ROT)) : h;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r  <= head.tag;
      a_val_r  <= (!head.tag.inl && (head.value == ALL_ONES)) ? HB'(0) : head.value;
      a_diff_r <= a_diff_nxt;
      b_tag_r  <= a_tag_r;
      b_val_r  <= a_val_r;
      b_neg_r  <= a_diff_r[mpnh_pkg::DIFF_W-1];
      b_lo_r   <= b_lo_nxt;
      b_hi_r   <= b_hi_nxt;
      c_tag_r  <= b_tag_r;
      c_hv_r   <= c_hv_nxt;
      if (c_valid_r && c_tag_r.last) begin
        out_data_r <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      num_r       <= '0;
    end else if (en) begin
      a_valid_r   <= head_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r && c_tag_r.last;
      if (c_valid_r) begin
        if (c_tag_r.last) begin
          num_r <= '0;
        end else if ((c_tag_r.kind == mpnh_pkg::KIND_RAT) && !c_tag_r.den) begin
          num_r <= h;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !en) |=> c_valid_r && $stable(c_hv_r))
    else $error("pipeline stage moved during stall");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (en && c_valid_r && c_tag_r.last) |=> out_valid_r)
    else $error("final part did not produce a result");
`endif

endmodule
